// ===== hw/rtl/ors_pkg.sv =====
// Shared types and constants for the 1-Wire ROM search engine.
`timescale 1ns / 1ps
package ors_pkg;

  localparam int unsigned ROM_BITS     = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned ROM_IDX_W    = 6;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CMD_SEARCH    = 8'hF0;
  localparam logic [7:0] CMD_ALARM     = 8'hEC;
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
  localparam logic [POS_W-1:0] LAST_POS     = 7'd64;
  localparam logic [7:0] CRC_POLY      = 8'h8C;

  localparam logic [1:0] KIND_BEGIN    = 2'd0;
  localparam logic [1:0] KIND_BIT      = 2'd1;
  localparam logic [1:0] KIND_RESTART  = 2'd2;

  typedef enum logic [3:0] {
    ST_STARTED     = 4'd0,
    ST_BIT_OK      = 4'd1,
    ST_FOUND       = 4'd2,
    ST_LAST        = 4'd3,
    ST_NONE        = 4'd4,
    ST_CRC_ERR     = 4'd5,
    ST_NO_PRESENCE = 4'd6,
    ST_LINE_LOW    = 4'd7,
    ST_IGNORED     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    OP_BEGIN_OK     = 3'd0,
    OP_BEGIN_FAIL   = 3'd1,
    OP_BIT_NONE     = 3'd2,
    OP_BIT_CONFLICT = 3'd3,
    OP_BIT_DATA     = 3'd4,
    OP_RESTART      = 3'd5,
    OP_IGNORE       = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    status_t    code;
    logic [7:0] cmd_byte;
    logic       data_bit;
  } cmd_t;

endpackage

// ===== hw/rtl/ors_front.sv =====
// Front end: decodes each input word into a classified command.
`timescale 1ns / 1ps
module ors_front
  import ors_pkg::*;
(
  input  logic [1:0] kind,
  input  logic       alarm_search,
  input  logic       line_high,
  input  logic       presence_seen,
  input  logic       id_bit,
  input  logic       complement_bit,
  output cmd_t       cmd
);

  always_comb begin
    cmd.op       = OP_IGNORE;
    cmd.code     = ST_IGNORED;
    cmd.cmd_byte = 8'h00;
    cmd.data_bit = id_bit;
    unique case (kind)
      KIND_BEGIN: begin
        if (!line_high) begin
          cmd.op   = OP_BEGIN_FAIL;
          cmd.code = ST_LINE_LOW;
        end else if (!presence_seen) begin
          cmd.op   = OP_BEGIN_FAIL;
          cmd.code = ST_NO_PRESENCE;
        end else begin
          cmd.op       = OP_BEGIN_OK;
          cmd.code     = ST_STARTED;
          cmd.cmd_byte = alarm_search ? CMD_ALARM : CMD_SEARCH;
        end
      end
      KIND_BIT: begin
        if (id_bit && complement_bit) begin
          cmd.op = OP_BIT_NONE;
        end else if (!id_bit && !complement_bit) begin
          cmd.op = OP_BIT_CONFLICT;
        end else begin
          cmd.op = OP_BIT_DATA;
        end
      end
      KIND_RESTART: begin
        cmd.op = OP_RESTART;
      end
      default: begin
        cmd.op = OP_IGNORE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ors_queue.sv =====
// Short command queue between the front end and the search back end.
`timescale 1ns / 1ps
module ors_queue
  import ors_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("Command queue count exceeds its depth.");

  a_read_drains: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (count == $past(count) - QCNT_W'(1)))
    else $error("Command queue count did not drop after a read.");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(wr_ptr - rd_ptr) == QPTR_W'(count))
    else $error("Command queue pointers disagree with its count.");

endmodule

// ===== hw/rtl/ors_back.sv =====
// Back end: runs the search state for each command and holds the result word.
`timescale 1ns / 1ps
module ors_back
  import ors_pkg::*;
#(
  parameter logic [3:0] CNT_LIMIT = 4'd15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_take,
  input  logic                pop,
  output logic                empty,
  output logic [3:0]          status,
  output logic [7:0]          command_byte,
  output logic                write_bit,
  output logic [ROM_BITS-1:0] rom_id,
  output logic [3:0]          device_index,
  output logic [3:0]          family_discrepancy
);

  logic [POS_W-1:0]    last_discrepancy, last_discrepancy_next;
  logic [POS_W-1:0]    zero_pick_pos, zero_pick_pos_next;
  logic [3:0]          family_disc_position, family_disc_position_next;
  logic [POS_W-1:0]    bit_position, bit_position_next;
  logic [ROM_BITS-1:0] current_rom, current_rom_next;
  logic [ROM_BITS-1:0] previous_rom, previous_rom_next;
  logic [7:0]          running_crc, running_crc_next;
  logic [3:0]          device_counter, device_counter_next;
  logic                pass_active, pass_active_next;

  logic                out_valid;
  status_t             res_status;
  logic [7:0]          res_cmd;
  logic                res_wbit;
  logic [ROM_BITS-1:0] res_rom;
  logic [3:0]          res_idx;
  logic [3:0]          res_fam;

  logic [POS_W-1:0]     pos;
  logic [ROM_IDX_W-1:0] pos_m1;
  logic                 dir;
  logic [ROM_BITS-1:0]  rom_upd;
  logic [7:0]           crc_upd;
  logic [POS_W-1:0]     lzp_upd;
  logic [3:0]           fdp_upd;
  logic                 do_clear;

  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
    logic [7:0] sh;
    sh = {1'b0, crc[7:1]};
    return (crc[0] ^ b) ? (sh ^ CRC_POLY) : sh;
  endfunction

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    pos = ((bit_position == '0) || (bit_position > LAST_POS)) ? POS_W'(1) : bit_position;
    pos_m1 = ROM_IDX_W'(pos - POS_W'(1));

    if (cmd.op == OP_BIT_CONFLICT) begin
      if (pos < last_discrepancy) begin
        dir = previous_rom[pos_m1];
      end else begin
        dir = (pos == last_discrepancy);
      end
    end else begin
      dir = cmd.data_bit;
    end

    lzp_upd = zero_pick_pos;
    fdp_upd = family_disc_position;
    if ((cmd.op == OP_BIT_CONFLICT) && !dir) begin
      lzp_upd = pos;
      if (pos < FAMILY_LIMIT) begin
        fdp_upd = 4'(pos);
      end
    end

    rom_upd         = current_rom;
    rom_upd[pos_m1] = dir;
    crc_upd         = crc_bit(running_crc, dir);
  end

  always_comb begin
    last_discrepancy_next     = last_discrepancy;
    zero_pick_pos_next        = zero_pick_pos;
    family_disc_position_next = family_disc_position;
    bit_position_next         = bit_position;
    current_rom_next          = current_rom;
    previous_rom_next         = previous_rom;
    running_crc_next          = running_crc;
    device_counter_next       = device_counter;
    pass_active_next          = pass_active;
    do_clear                  = 1'b0;

    res_status = ST_IGNORED;
    res_cmd    = 8'h00;
    res_wbit   = 1'b0;
    res_rom    = '0;
    res_idx    = device_counter;
    res_fam    = family_disc_position;

    unique case (cmd.op)
      OP_BEGIN_OK: begin
        pass_active_next   = 1'b1;
        zero_pick_pos_next = '0;
        bit_position_next  = POS_W'(1);
        running_crc_next   = '0;
        current_rom_next   = '0;
        res_status         = ST_STARTED;
        res_cmd            = cmd.cmd_byte;
      end
      OP_BEGIN_FAIL: begin
        do_clear   = 1'b1;
        res_status = cmd.code;
        res_idx    = '0;
        res_fam    = '0;
      end
      OP_BIT_NONE: begin
        if (pass_active) begin
          do_clear   = 1'b1;
          res_status = ST_NONE;
          res_idx    = '0;
          res_fam    = '0;
        end
      end
      OP_BIT_CONFLICT, OP_BIT_DATA: begin
        if (pass_active) begin
          zero_pick_pos_next        = lzp_upd;
          family_disc_position_next = fdp_upd;
          current_rom_next          = rom_upd;
          running_crc_next          = crc_upd;
          res_wbit                  = dir;
          res_rom                   = rom_upd;
          res_fam                   = fdp_upd;
          if (pos < LAST_POS) begin
            bit_position_next = pos + POS_W'(1);
            res_status        = ST_BIT_OK;
          end else if (crc_upd != '0) begin
            do_clear   = 1'b1;
            res_status = ST_CRC_ERR;
          end else begin
            last_discrepancy_next = lzp_upd;
            previous_rom_next     = rom_upd;
            pass_active_next      = 1'b0;
            bit_position_next     = POS_W'(1);
            running_crc_next      = '0;
            zero_pick_pos_next    = '0;
            if (lzp_upd == '0) begin
              do_clear   = 1'b1;
              res_status = ST_LAST;
            end else begin
              res_status = ST_FOUND;
              if (device_counter < CNT_LIMIT) begin
                device_counter_next = device_counter + 4'd1;
              end
            end
          end
        end
      end
      OP_RESTART: begin
        do_clear = 1'b1;
        res_idx  = '0;
        res_fam  = '0;
      end
      OP_IGNORE: begin
        res_status = ST_IGNORED;
      end
      default: begin
        res_status = ST_IGNORED;
      end
    endcase

    if (do_clear) begin
      last_discrepancy_next     = '0;
      zero_pick_pos_next        = '0;
      family_disc_position_next = '0;
      bit_position_next         = POS_W'(1);
      current_rom_next          = '0;
      previous_rom_next         = '0;
      running_crc_next          = '0;
      device_counter_next       = '0;
      pass_active_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_discrepancy     <= '0;
      zero_pick_pos        <= '0;
      family_disc_position <= '0;
      bit_position         <= POS_W'(1);
      current_rom          <= '0;
      previous_rom         <= '0;
      running_crc          <= '0;
      device_counter       <= '0;
      pass_active          <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (cmd_take) begin
        last_discrepancy     <= last_discrepancy_next;
        zero_pick_pos        <= zero_pick_pos_next;
        family_disc_position <= family_disc_position_next;
        bit_position         <= bit_position_next;
        current_rom          <= current_rom_next;
        previous_rom         <= previous_rom_next;
        running_crc          <= running_crc_next;
        device_counter       <= device_counter_next;
        pass_active          <= pass_active_next;
        out_valid            <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      status             <= res_status;
      command_byte       <= res_cmd;
      write_bit          <= res_wbit;
      rom_id             <= res_rom;
      device_index       <= res_idx;
      family_discrepancy <= res_fam;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (bit_position >= POS_W'(1)) && (bit_position <= LAST_POS))
    else $error("Bit position left the range of ROM bits.");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !pass_active |-> (bit_position == POS_W'(1)))
    else $error("Bit position not rewound while no pass is active.");

  a_counter_limit: assert property (@(posedge clk) disable iff (rst)
    device_counter <= CNT_LIMIT)
    else $error("Device counter passed its limit.");

  a_family_range: assert property (@(posedge clk) disable iff (rst)
    family_disc_position < 4'(FAMILY_LIMIT))
    else $error("Family discrepancy outside the family code bits.");

  a_found_advances: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && (res_status == ST_FOUND) && (device_counter < CNT_LIMIT))
      |=> (device_counter == $past(device_counter) + 4'd1))
    else $error("Device counter did not advance after a found device.");

endmodule

// ===== hw/rtl/onewire_rom_search_engine_core.sv =====
// A pushed word passes the command queue, then the result register; the two-entry queue and
// the result register let each side stall on its own. Throughput: one word per cycle in both
// directions; the back end retires one command per cycle when its result slot is free or popped.
// Reset (rst, synchronous, active high) empties the queue and the result register and clears
// the search state, with the bit position back at one; no memory sweep is needed.
`timescale 1ns / 1ps
module onewire_rom_search_engine_core
  import ors_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic                alarm_search,
  input  logic                line_high,
  input  logic                presence_seen,
  input  logic                id_bit,
  input  logic                complement_bit,
  input  logic                pop,
  output logic                empty,
  output logic [3:0]          status,
  output logic [7:0]          command_byte,
  output logic                write_bit,
  output logic [ROM_BITS-1:0] rom_id,
  output logic [3:0]          device_index,
  output logic [3:0]          family_discrepancy
);

  localparam int unsigned LIMIT_RAW = (MAX_DEVICES > 1) ? (MAX_DEVICES - 1) : 0;
  localparam logic [3:0]  CNT_LIMIT = (LIMIT_RAW > 15) ? 4'd15 : 4'(LIMIT_RAW);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_take;

  ors_front u_front (
    .kind           (kind),
    .alarm_search   (alarm_search),
    .line_high      (line_high),
    .presence_seen  (presence_seen),
    .id_bit         (id_bit),
    .complement_bit (complement_bit),
    .cmd            (front_cmd)
  );

  ors_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (head_take),
    .rd_valid (head_valid),
    .rd_data  (head_cmd)
  );

  ors_back #(
    .CNT_LIMIT (CNT_LIMIT)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (head_valid),
    .cmd                (head_cmd),
    .cmd_take           (head_take),
    .pop                (pop),
    .empty              (empty),
    .status             (status),
    .command_byte       (command_byte),
    .write_bit          (write_bit),
    .rom_id             (rom_id),
    .device_index       (device_index),
    .family_discrepancy (family_discrepancy)
  );

endmodule
